// ===== rtl/core/sdr_usb_frame_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// sdr_usb_frame_deframer_macros.svh
// Assertion macros for the receiver frame deframer.
// ----------------------------------------------------------------------------
`ifndef SDR_USB_FRAME_DEFRAMER_MACROS_SVH
`define SDR_USB_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SUFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sufd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SUFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sufd assertion failed");

`endif

// ===== rtl/core/sufd_pkg.sv =====
// ----------------------------------------------------------------------------
// sufd_pkg
// Types and constants shared by the receiver frame deframer modules.
// ----------------------------------------------------------------------------
package sufd_pkg;

    localparam int SAMPLE_GROUPS_DEF = 63;
    localparam int HEADER_BYTES      = 8;
    localparam int SYNC_BYTES        = 3;
    localparam int POS_W             = 9;
    localparam logic [7:0] SYNC_RESET = 8'h7F;

    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_CONTROL   = 2'd1,
        KIND_SYNC_LOST = 2'd2
    } sufd_kind_t;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] data_byte;
    } sufd_beat_t;

    typedef struct packed {
        sufd_kind_t   result_kind;
        logic [15:0]  second_value;
        logic [15:0]  first_value;
        logic [4:0]   control_address;
        logic         keys_changed;
        logic         dot_key;
        logic         dash_key;
        logic         push_to_talk;
        logic [15:0]  mic_channel;
        logic [23:0]  right_channel;
        logic [23:0]  left_channel;
    } sufd_result_t;

    typedef struct packed {
        logic advance;
        logic result_present;
    } sufd_ctrl_t;

endpackage

// ===== rtl/core/sufd_in_stage.sv =====
// ----------------------------------------------------------------------------
// sufd_in_stage
// Input register: holds one accepted beat until the decoder takes it.
// ----------------------------------------------------------------------------
module sufd_in_stage
    import sufd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  sufd_beat_t beat_in,
    input  logic       advance,
    output logic       beat_valid,
    output sufd_beat_t beat_out
);

    logic       valid_reg, valid_next;
    sufd_beat_t beat_reg, beat_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            beat_next  = beat_in;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        beat_reg <= beat_next;
    end

    assign beat_valid = valid_reg;
    assign beat_out   = beat_reg;

endmodule

// ===== rtl/core/sufd_decoder.sv =====
// ----------------------------------------------------------------------------
// sufd_decoder
// Frame position tracking, sync check and field capture for one byte.
// ----------------------------------------------------------------------------
module sufd_decoder
    import sufd_pkg::*;
#(
    parameter int SAMPLE_GROUPS = SAMPLE_GROUPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_data,
    input  logic         advance,
    input  sufd_beat_t   beat,
    output logic         result_present,
    output sufd_result_t result
);

    localparam int FRAME_BYTES = HEADER_BYTES + 8 * SAMPLE_GROUPS;
    localparam logic [POS_W:0] FRAME_LEN = (POS_W + 1)'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_SYNC_END = POS_W'(SYNC_BYTES);
    localparam logic [POS_W-1:0] POS_CTRL_LAST = POS_W'(HEADER_BYTES - 1);

    logic [7:0]       sync_reg, sync_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             in_sync_reg, in_sync_next;
    logic [7:0]       head_reg, head_next;
    logic [31:0]      payload_reg, payload_next;
    logic [55:0]      shift_reg, shift_next;
    logic [2:0]       keys_reg, keys_next;

    logic             in_sync_eff;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W:0]   pos_inc;
    logic [63:0]      group;

    always_comb begin
        sync_next      = cfg_valid ? cfg_data : sync_reg;
        pos_next       = pos_reg;
        in_sync_next   = in_sync_reg;
        head_next      = head_reg;
        payload_next   = payload_reg;
        shift_next     = shift_reg;
        keys_next      = keys_reg;
        result_present = 1'b0;
        result         = '0;
        result.result_kind = KIND_SAMPLE;

        in_sync_eff = beat.frame_start || in_sync_reg;
        pos_eff     = beat.frame_start ? '0 : pos_reg;
        pos_inc     = {1'b0, pos_eff} + 1'b1;
        group       = {shift_reg, beat.data_byte};

        if (advance && in_sync_eff) begin
            in_sync_next = 1'b1;
            pos_next     = (pos_inc >= FRAME_LEN) ? '0 : pos_inc[POS_W-1:0];
            if (pos_eff < POS_SYNC_END) begin
                if (beat.data_byte != sync_reg) begin
                    in_sync_next       = 1'b0;
                    pos_next           = '0;
                    result_present     = 1'b1;
                    result.result_kind = KIND_SYNC_LOST;
                end
            end else if (pos_eff == POS_SYNC_END) begin
                head_next = beat.data_byte;
            end else if (pos_eff <= POS_CTRL_LAST) begin
                payload_next = {payload_reg[23:0], beat.data_byte};
                if (pos_eff == POS_CTRL_LAST) begin
                    keys_next              = head_reg[2:0];
                    result_present         = 1'b1;
                    result.result_kind     = KIND_CONTROL;
                    result.push_to_talk    = head_reg[0];
                    result.dash_key        = head_reg[1];
                    result.dot_key         = head_reg[2];
                    result.keys_changed    = head_reg[2:0] != keys_reg;
                    result.control_address = head_reg[7:3];
                    result.first_value     = payload_next[31:16];
                    result.second_value    = payload_next[15:0];
                end
            end else if (pos_eff[2:0] != 3'd7) begin
                shift_next = group[55:0];
            end else begin
                result_present       = 1'b1;
                result.result_kind   = KIND_SAMPLE;
                result.left_channel  = group[63:40];
                result.right_channel = group[39:16];
                result.mic_channel   = group[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= SYNC_RESET;
            pos_reg     <= '0;
            in_sync_reg <= 1'b0;
            keys_reg    <= '0;
        end else begin
            sync_reg    <= sync_next;
            pos_reg     <= pos_next;
            in_sync_reg <= in_sync_next;
            keys_reg    <= keys_next;
        end
        head_reg    <= head_next;
        payload_reg <= payload_next;
        shift_reg   <= shift_next;
    end

endmodule

// ===== rtl/core/sufd_out_stage.sv =====
// ----------------------------------------------------------------------------
// sufd_out_stage
// Result register toward the master side.
// ----------------------------------------------------------------------------
module sufd_out_stage
    import sufd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  sufd_ctrl_t   ctrl,
    input  sufd_result_t result_in,
    input  logic         m_tready,
    output logic         m_tvalid,
    output sufd_result_t result_out
);

    logic         valid_reg, valid_next;
    sufd_result_t result_reg, result_next;

    always_comb begin
        valid_next  = valid_reg;
        result_next = result_reg;
        if (ctrl.advance) begin
            valid_next = ctrl.result_present;
            if (ctrl.result_present) begin
                result_next = result_in;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        result_reg <= result_next;
    end

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== rtl/core/sdr_usb_frame_deframer.sv =====
// An accepted beat waits in the input register; the combinational decoder
// passes its result into the result register on m_. Throughput: one byte
// per cycle unless m_ stalls; the two registers decouple the sides around it.
// Reset (aresetn, synchronous, active low) clears both stages, the frame
// position and sync flag, the stored keys, and loads sync_value with 0x7F.
// ----------------------------------------------------------------------------
// sdr_usb_frame_deframer
// Receiver frame deframer: sync check, control decode and sample unpacking.
// ----------------------------------------------------------------------------
`include "sdr_usb_frame_deframer_macros.svh"

module sdr_usb_frame_deframer
    import sufd_pkg::*;
#(
    parameter int SAMPLE_GROUPS = SAMPLE_GROUPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,     // sync_value
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // data_byte
    input  logic [0:0]   s_tuser,      // frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_channel[23:0], right_channel[47:24], mic_channel[63:48],
    // push_to_talk[64], dash_key[65], dot_key[66], keys_changed[67],
    // control_address[72:68], first_value[88:73], second_value[104:89]
    output logic [111:0] m_tdata,
    output logic [1:0]   m_tuser       // result_kind
);

    sufd_beat_t   beat_in, beat;
    logic         beat_valid;
    sufd_ctrl_t   ctrl;
    sufd_result_t dec_result, out_result;

    assign cfg_ready = 1'b1;

    assign beat_in.data_byte   = s_tdata;
    assign beat_in.frame_start = s_tuser[0];

    assign ctrl.advance = beat_valid && (!m_tvalid || m_tready);

    sufd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .beat_in    (beat_in),
        .advance    (ctrl.advance),
        .beat_valid (beat_valid),
        .beat_out   (beat)
    );

    sufd_decoder #(
        .SAMPLE_GROUPS (SAMPLE_GROUPS)
    ) u_dec (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .advance        (ctrl.advance),
        .beat           (beat),
        .result_present (ctrl.result_present),
        .result         (dec_result)
    );

    sufd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .result_in  (dec_result),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result_out (out_result)
    );

    assign m_tuser = out_result.result_kind;
    assign m_tdata = {7'd0, out_result.second_value, out_result.first_value,
                      out_result.control_address, out_result.keys_changed,
                      out_result.dot_key, out_result.dash_key,
                      out_result.push_to_talk, out_result.mic_channel,
                      out_result.right_channel, out_result.left_channel};

    `SUFD_ASSERT_IMPLIES(a_sync_lost_empty, aclk, aresetn, m_tvalid && (m_tuser == KIND_SYNC_LOST), m_tdata == '0)
    `SUFD_ASSERT_IMPLIES(a_sample_no_ctrl, aclk, aresetn, m_tvalid && (m_tuser == KIND_SAMPLE), m_tdata[111:64] == '0)
    `SUFD_ASSERT_IMPLIES(a_full_blocks_input, aclk, aresetn, beat_valid && m_tvalid && !m_tready, !s_tready)
    `SUFD_ASSERT_NEXT(a_stall_holds_result, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the receiver frame deframer. Byte beats go in on the s_
// stream and every beat is run through a model of the frame state kept in a
// scoreboard. Each result beat on m_ is compared field by field with the
// oldest predicted result. The run covers directed frames, then random
// frames under three idle patterns and three sync byte settings.
// ----------------------------------------------------------------------------
module tb_top;
    import sufd_pkg::*;

    localparam int FRAME_BYTES   = HEADER_BYTES + 8 * SAMPLE_GROUPS_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 120;
    localparam int TIMEOUT_NS    = 1_600_000;
    localparam int REPORT_LIMIT  = 10;

    class deframe_scoreboard;
        logic [7:0]   sync_byte;
        int           position;
        bit           in_sync;
        logic [7:0]   ctrl_head;
        logic [31:0]  ctrl_payload;
        logic [55:0]  sample_bits;
        logic [2:0]   last_keys;
        sufd_result_t expected_q[$];
        int           mismatches;
        int           results_seen;

        function new();
            sync_byte    = SYNC_RESET;
            position     = 0;
            in_sync      = 1'b0;
            ctrl_head    = '0;
            ctrl_payload = '0;
            sample_bits  = '0;
            last_keys    = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void take_byte(input logic [7:0] b, input logic first);
            sufd_result_t r;
            r = '0;
            if (first) begin
                position = 0;
                in_sync  = 1'b1;
            end
            if (!in_sync) return;
            if (position < SYNC_BYTES) begin
                if (b != sync_byte) begin
                    in_sync  = 1'b0;
                    position = 0;
                    r.result_kind = KIND_SYNC_LOST;
                    expected_q.push_back(r);
                    return;
                end
            end else if (position == SYNC_BYTES) begin
                ctrl_head = b;
            end else if (position < HEADER_BYTES) begin
                ctrl_payload = {ctrl_payload[23:0], b};
                if (position == HEADER_BYTES - 1) begin
                    r.result_kind     = KIND_CONTROL;
                    r.push_to_talk    = ctrl_head[0];
                    r.dash_key        = ctrl_head[1];
                    r.dot_key         = ctrl_head[2];
                    r.keys_changed    = (ctrl_head[2:0] != last_keys);
                    r.control_address = ctrl_head[7:3];
                    r.first_value     = ctrl_payload[31:16];
                    r.second_value    = ctrl_payload[15:0];
                    last_keys = ctrl_head[2:0];
                    expected_q.push_back(r);
                end
            end else if (((position - HEADER_BYTES) % 8) < 7) begin
                sample_bits = {sample_bits[47:0], b};
            end else begin
                r.result_kind   = KIND_SAMPLE;
                r.left_channel  = sample_bits[55:32];
                r.right_channel = sample_bits[31:8];
                r.mic_channel   = {sample_bits[7:0], b};
                expected_q.push_back(r);
            end
            position++;
            if (position >= FRAME_BYTES) position = 0;
        endfunction

        function void compare_field(input string name, input logic [23:0] e,
                                    input logic [23:0] a);
            if (a !== e) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat %0d: %s expected %h, got %h",
                             results_seen, name, e, a);
            end
        endfunction

        function void match_result(input logic [111:0] tdata, input logic [1:0] tuser);
            sufd_result_t e;
            sufd_result_t a;
            a.result_kind     = sufd_kind_t'(tuser);
            a.left_channel    = tdata[23:0];
            a.right_channel   = tdata[47:24];
            a.mic_channel     = tdata[63:48];
            a.push_to_talk    = tdata[64];
            a.dash_key        = tdata[65];
            a.dot_key         = tdata[66];
            a.keys_changed    = tdata[67];
            a.control_address = tdata[72:68];
            a.first_value     = tdata[88:73];
            a.second_value    = tdata[104:89];
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat %0d: unexpected, kind %0d data %h",
                             results_seen, tuser, tdata);
                return;
            end
            e = expected_q.pop_front();
            compare_field("result_kind", e.result_kind, a.result_kind);
            compare_field("left_channel", e.left_channel, a.left_channel);
            compare_field("right_channel", e.right_channel, a.right_channel);
            compare_field("mic_channel", e.mic_channel, a.mic_channel);
            compare_field("push_to_talk", e.push_to_talk, a.push_to_talk);
            compare_field("dash_key", e.dash_key, a.dash_key);
            compare_field("dot_key", e.dot_key, a.dot_key);
            compare_field("keys_changed", e.keys_changed, a.keys_changed);
            compare_field("control_address", e.control_address, a.control_address);
            compare_field("first_value", e.first_value, a.first_value);
            compare_field("second_value", e.second_value, a.second_value);
        endfunction
    endclass

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;      // data_byte
    logic [0:0]   s_tuser   = '0;      // frame_start
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // left_channel, right_channel, mic_channel, push_to_talk, dash_key,
    // dot_key, keys_changed, control_address, first_value, second_value
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;             // result_kind

    deframe_scoreboard sb = new();

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_left     = 0;
    bit         hold_request  = 1'b0;
    int         bytes_sent    = 0;
    logic [7:0] cur_sync      = SYNC_RESET;
    logic [2:0] gen_keys      = '0;

    sdr_usb_frame_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // receiver backpressure: random stalls plus a long hold when one is requested
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.match_result(m_tdata, m_tuser);
    end

    // called at a falling edge, returns at a falling edge
    task send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b, first);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task write_sync(input logic [7:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.sync_byte = v;
        cur_sync     = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // bad_pos < 0 keeps all three sync bytes good
    task send_frame(input int n_bytes, input bit with_start, input int bad_pos);
        logic [7:0] b;
        for (int i = 0; i < n_bytes; i++) begin
            if (i < SYNC_BYTES) begin
                b = (i == bad_pos) ? cur_sync ^ 8'($urandom_range(1, 255)) : cur_sync;
            end else if (i == SYNC_BYTES) begin
                if ($urandom_range(0, 1)) gen_keys = 3'($urandom);
                b = {5'($urandom), gen_keys};
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, with_start && (i == 0));
        end
    endtask

    task run_traffic(input int goal);
        int base;
        int sel;
        int len;
        base = bytes_sent;
        while (bytes_sent - base < goal) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                send_frame($urandom_range(3, 12), 1'b1, $urandom_range(0, 2));
            end else if (sel < 25) begin
                send_frame($urandom_range(1, 7), 1'b1, -1);
            end else begin
                len = HEADER_BYTES + 8 * $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 7);
                send_frame(len, 1'b1, -1);
            end
        end
    endtask

    initial begin
        @(posedge aresetn);
        @(negedge aclk);
        send_idle_pct = 10;
        recv_idle_pct = 69;

        // bytes ahead of the first frame start are dropped
        send_byte(SYNC_RESET, 1'b0);
        send_byte(8'hA5, 1'b0);
        // header with all keys and full address, then one extreme sample group
        send_byte(SYNC_RESET, 1'b1);
        send_byte(SYNC_RESET, 1'b0);
        send_byte(SYNC_RESET, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        // realign mid-frame, then lose sync on the second sync byte
        send_byte(SYNC_RESET, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(SYNC_RESET, 1'b0);
        send_byte(SYNC_RESET, 1'b0);
        // wrong first sync byte
        send_byte(8'h00, 1'b1);

        write_sync(8'hFF);
        run_traffic(12);
        drain_results();
        run_traffic(12);

        write_sync(8'h00);
        send_idle_pct = 69;
        recv_idle_pct = 10;
        run_traffic(24);

        write_sync(8'($urandom_range(1, 254)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        // full frame wraps to a back-to-back frame without a start marker
        send_frame(FRAME_BYTES, 1'b1, -1);
        send_frame(HEADER_BYTES + 8, 1'b0, -1);

        drain_results();
        repeat (10) @(negedge aclk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
